FILE: hw/rtl/asl_pkg.sv
package asl_pkg;

    // width of the line and column counters (8 to 32)
    localparam int CNT_W = 16;
    localparam int FIELD_W = 16;

    // open token kinds
    localparam logic [2:0] OPEN_NONE      = 3'd0;
    localparam logic [2:0] OPEN_SYMBOL    = 3'd1;
    localparam logic [2:0] OPEN_DIRECTIVE = 3'd2;
    localparam logic [2:0] OPEN_LITERAL   = 3'd3;
    localparam logic [2:0] OPEN_ADDRESS   = 3'd4;
    localparam logic [2:0] OPEN_COMMENT   = 3'd5;

    // token classes
    localparam logic [2:0] CLS_INSTRUCTION = 3'd0;
    localparam logic [2:0] CLS_REGISTER    = 3'd1;
    localparam logic [2:0] CLS_LABEL       = 3'd2;
    localparam logic [2:0] CLS_DIRECTIVE   = 3'd3;
    localparam logic [2:0] CLS_LITERAL     = 3'd4;
    localparam logic [2:0] CLS_ADDRESS     = 3'd5;
    localparam logic [2:0] CLS_COMMENT     = 3'd6;

    // record kinds
    localparam logic [1:0] REC_VALUE    = 2'd0;
    localparam logic [1:0] REC_END      = 2'd1;
    localparam logic [1:0] REC_ERROR    = 2'd2;
    localparam logic [1:0] REC_TEXT_END = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;

    localparam logic [CNT_W-1:0] LINE_INIT = CNT_W'(2);
    localparam logic [CNT_W-1:0] COL_INIT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // request from the input stage to the lexer core
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } t_step_req;

    // one result record
    typedef struct packed {
        logic [1:0]         record_kind;
        logic [2:0]         token_class;
        logic [7:0]         out_char;
        logic [FIELD_W-1:0] line_number;
        logic [FIELD_W-1:0] column_number;
        logic               had_error;
    } t_record;

    // clamp a counter to the output field
    function automatic logic [FIELD_W-1:0] clamp_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+FIELD_W-1:0] w;
        w = (CNT_W+FIELD_W)'(v);
        if (w > (CNT_W+FIELD_W)'({FIELD_W{1'b1}})) begin
            return {FIELD_W{1'b1}};
        end
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [2:0] class_of(input logic [7:0] c);
        logic [2:0] k;
        k = OPEN_NONE;
        if (c == CH_HASH) begin
            k = OPEN_LITERAL;
        end else if (c == CH_DOLL) begin
            k = OPEN_ADDRESS;
        end else if (c == CH_DOT) begin
            k = OPEN_DIRECTIVE;
        end else if (c == CH_SEMI) begin
            k = OPEN_COMMENT;
        end else if (is_alnum(c)) begin
            k = OPEN_SYMBOL;
        end
        return k;
    endfunction

    function automatic logic ends_token(input logic [7:0] c);
        return c == CH_RPAR || c == CH_COMMA || c == CH_NL || c == CH_COLON ||
               c == CH_SPACE || c == CH_SEMI;
    endfunction

endpackage

FILE: hw/rtl/asl_char_if.sv
interface asl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink (input valid, input text_char, output ready);
endinterface

FILE: hw/rtl/asl_rec_if.sv
interface asl_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [2:0]  token_class;
    logic [7:0]  out_char;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        had_error;

    modport source (output valid, output record_kind, output token_class, output out_char,
                    output line_number, output column_number, output had_error,
                    input ready);
    modport sink (input valid, input record_kind, input token_class, input out_char,
                  input line_number, input column_number, input had_error,
                  output ready);
endinterface

FILE: hw/rtl/asl_in_stage.sv
module asl_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_char,
    output logic               o_ready,
    input  logic               i_advance,
    output asl_pkg::t_step_req o_req
);
    import asl_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;

    // free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.ch    = r_char;

endmodule

FILE: hw/rtl/asl_core.sv
module asl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asl_pkg::t_step_req i_req,
    output logic               o_advance,
    output logic               o_valid,
    input  logic               i_ready,
    output asl_pkg::t_record   o_rec
);
    import asl_pkg::*;

    logic [2:0]       r_open, n_open;
    logic [7:0]       r_first, n_first;
    logic [1:0]       r_count, n_count;
    logic [CNT_W-1:0] r_line, n_line;
    logic [CNT_W-1:0] r_col, n_col;
    logic             r_err, n_err;
    logic             r_out_valid;
    t_record          r_out;

    logic    emit;
    logic    upd_cnt;
    logic    is_end;
    logic    send;
    logic    is_reg;
    logic    out_free;
    t_record rec;
    logic [7:0] c;

    assign c        = i_req.ch;
    assign out_free = !r_out_valid || i_ready;
    assign o_advance = i_req.valid && out_free;

    // one lexer step on the held byte
    always_comb begin
        n_open  = r_open;
        n_first = r_first;
        n_count = r_count;
        n_line  = r_line;
        n_col   = r_col;
        n_err   = r_err;
        emit    = 1'b0;
        upd_cnt = 1'b0;
        send    = 1'b0;
        rec.record_kind   = REC_VALUE;
        rec.token_class   = CLS_INSTRUCTION;
        rec.out_char      = CH_NUL;
        rec.line_number   = clamp_field(r_line);
        rec.column_number = clamp_field(r_col);
        rec.had_error     = 1'b0;
        is_end = (r_open == OPEN_COMMENT) ? (c == CH_NL) : ends_token(c);
        is_reg = (r_count == 2'd1) &&
                 (r_first == CH_A || r_first == CH_X || r_first == CH_Y);

        if (c == CH_NUL) begin
            // end of text restarts the block
            emit = 1'b1;
            rec.record_kind = REC_TEXT_END;
            rec.had_error   = r_err;
            n_open  = OPEN_NONE;
            n_first = CH_NUL;
            n_count = 2'd0;
            n_line  = LINE_INIT;
            n_col   = COL_INIT;
            n_err   = 1'b0;
        end else if (!r_err) begin
            if (is_end && r_open != OPEN_NONE) begin
                if (c == CH_COLON && r_open != OPEN_SYMBOL && r_open != OPEN_DIRECTIVE) begin
                    emit = 1'b1;
                    rec.record_kind = REC_ERROR;
                    rec.out_char    = c;
                    n_err = 1'b1;
                end else begin
                    emit    = 1'b1;
                    upd_cnt = 1'b1;
                    rec.record_kind = REC_END;
                    if (c == CH_COLON) begin
                        rec.token_class = CLS_LABEL;
                    end else begin
                        case (r_open)
                            OPEN_SYMBOL:    rec.token_class = is_reg ? CLS_REGISTER
                                                                     : CLS_INSTRUCTION;
                            OPEN_DIRECTIVE: rec.token_class = CLS_DIRECTIVE;
                            OPEN_LITERAL:   rec.token_class = CLS_LITERAL;
                            OPEN_ADDRESS:   rec.token_class = CLS_ADDRESS;
                            default:        rec.token_class = CLS_COMMENT;
                        endcase
                    end
                    n_open  = (c == CH_SEMI) ? OPEN_COMMENT : OPEN_NONE;
                    n_count = 2'd0;
                    n_first = CH_NUL;
                end
            end else begin
                upd_cnt = 1'b1;
                if (r_open == OPEN_NONE) begin
                    n_open = class_of(c);
                    send   = (class_of(c) == OPEN_SYMBOL);
                end else if (r_open != OPEN_COMMENT) begin
                    if (class_of(c) != OPEN_SYMBOL) begin
                        if (!(r_open == OPEN_LITERAL && c == CH_DOLL)) begin
                            emit    = 1'b1;
                            upd_cnt = 1'b0;
                            rec.record_kind = REC_ERROR;
                            rec.out_char    = c;
                            n_err = 1'b1;
                        end
                    end else begin
                        send = 1'b1;
                    end
                end else begin
                    send = 1'b1;
                end
                if (send) begin
                    if (r_count == 2'd0) begin
                        n_first = c;
                    end
                    if (r_count != 2'd2) begin
                        n_count = r_count + 2'd1;
                    end
                    emit = 1'b1;
                    rec.record_kind = REC_VALUE;
                    rec.token_class = (n_open == OPEN_COMMENT) ? CLS_COMMENT
                                                               : CLS_INSTRUCTION;
                    rec.out_char    = c;
                end
            end
            // line and column bookkeeping
            if (upd_cnt) begin
                if (c == CH_NL) begin
                    n_line = sat_inc(r_line);
                    n_col  = COL_INIT;
                end else begin
                    n_col  = sat_inc(r_col);
                end
            end
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= OPEN_NONE;
            r_first <= CH_NUL;
            r_count <= 2'd0;
            r_line  <= LINE_INIT;
            r_col   <= COL_INIT;
            r_err   <= 1'b0;
        end else if (o_advance) begin
            r_open  <= n_open;
            r_first <= n_first;
            r_count <= n_count;
            r_line  <= n_line;
            r_col   <= n_col;
            r_err   <= n_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (o_advance && emit) begin
            r_out <= rec;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rec   = r_out;

    // an error stays until a zero byte
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && r_err && c != CH_NUL |=> r_err)
        else $error("error flag dropped without end of text");

    // counters freeze after an error
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && r_err && c != CH_NUL |=> $stable(r_line) && $stable(r_col))
        else $error("counters moved after error");

    // end of text returns to reset state
    a_text_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && c == CH_NUL |=> r_open == OPEN_NONE && r_line == LINE_INIT &&
                                     r_col == COL_INIT && !r_err && r_count == 2'd0)
        else $error("end of text did not restart the lexer");

    // value count saturates at two
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("value count overflow");

endmodule

FILE: hw/rtl/assembly_line_lexer.sv
// channel  | dir | handshake     | payload
// i_text   | in  | valid / ready | text_char
// o_rec    | out | valid / ready | record_kind, token_class, out_char,
//          |     |               | line_number, column_number, had_error
//
// one byte per cycle sustained while the output is not stalled; a byte's record is registered
// after its transfer (input register, then the lexer step into the result register)
// the lexer state update is combinational logic on the held byte, so bytes follow back to back
// synchronous active-low reset clears the lexer state and both valid flags
// a stalled output holds the record; the input register still takes a byte until full
// a held byte waits while the result register is full and stalled, even if it makes no record
module assembly_line_lexer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    asl_char_if.sink i_text,
    asl_rec_if.source o_rec
);
    import asl_pkg::*;

    t_step_req req;
    t_record   rec;
    logic      advance;
    logic      rec_valid;

    // input register
    asl_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_text.valid),
        .i_char    (i_text.text_char),
        .o_ready   (i_text.ready),
        .i_advance (advance),
        .o_req     (req)
    );

    // lexer step and result register
    asl_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_advance (advance),
        .o_valid   (rec_valid),
        .i_ready   (o_rec.ready),
        .o_rec     (rec)
    );

    assign o_rec.valid         = rec_valid;
    assign o_rec.record_kind   = rec.record_kind;
    assign o_rec.token_class   = rec.token_class;
    assign o_rec.out_char      = rec.out_char;
    assign o_rec.line_number   = rec.line_number;
    assign o_rec.column_number = rec.column_number;
    assign o_rec.had_error     = rec.had_error;

endmodule
